// ===== rtl/core/asm_pkg.sv =====
// ----------------------------------------------------------------------------
// asm_pkg: shared types and constants of the approximate substring matcher
// Holds field widths, register indexes and the request and wave structures
// that travel between the cells, the result stage and the top level.
// ----------------------------------------------------------------------------
package asm_pkg;

  // Pattern storage is fixed at two 64-bit words.
  localparam int PATTERN_BYTES       = 16;
  localparam int MAX_PATTERN_DEFAULT = 16;

  // Distances never exceed the number of pattern rows, so five bits suffice.
  localparam int DIST_W      = 5;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_FIRST_EIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LAST_EIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE        = 2'd3;

  // Input request: one text byte.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_req_t;

  // Output request: one result per text byte.
  typedef struct packed {
    logic [DIST_W-1:0] end_distance;
    logic              match_here;
    logic              found;
    logic              last_result;
  } match_rsp_t;

  // Data handed from one cell to the next along the row.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
    logic [DIST_W-1:0] new_dist;  // this byte's value of the row above
    logic [DIST_W-1:0] old_dist;  // previous byte's value of the row above
    logic [DIST_W-1:0] sel_dist;  // value of the row picked by pattern_length
  } asm_wave_t;

endpackage

// ===== rtl/core/asm_stream_if.sv =====
// ----------------------------------------------------------------------------
// asm_stream_if: valid/ready channel
// Carries one request of type payload_t from a source to a sink.
// ----------------------------------------------------------------------------
interface asm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/approximate_substring_match_top.sv =====
// ----------------------------------------------------------------------------
// approximate_substring_match_top: streaming approximate substring matcher
// Reports per text byte the least unit-cost edit distance between the pattern
// and any substring ending at that byte, with match and sticky found flags.
//
//   channel  dir  payload                                        handshake
//   text     in   text_byte, end_of_text                         valid/ready
//   result   out  end_distance, match_here, found, last_result   valid/ready
//   cfg      in   cfg_index, cfg_data                            cfg_write_enable
//
// One byte enters per cycle while the result sink keeps up; a byte's result is
// registered in each of the ROWS cells and then in the output stage, ROWS being the
// number of cells (the smaller of MAX_PATTERN and 16), one pattern row per cell.
// Synchronous reset clears the row to distance i in row i and drops all
// results in flight. A stalled result holds the whole row of cells still.
// ----------------------------------------------------------------------------
module approximate_substring_match_top #(
  parameter int MAX_PATTERN = asm_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [asm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asm_pkg::CFG_DATA_W-1:0]  cfg_data,
  asm_stream_if.sink                      text,
  asm_stream_if.source                    result
);
  import asm_pkg::*;

  localparam int ROWS = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

  logic [CFG_DATA_W-1:0]        pattern_first_eight;
  logic [CFG_DATA_W-1:0]        pattern_last_eight;
  logic [DIST_W-1:0]            pattern_length;
  logic [DIST_W-1:0]            max_distance;
  logic [2*CFG_DATA_W-1:0]      pattern_bytes;
  logic [DIST_W-1:0]            pattern_len;
  logic                         advance;
  text_req_t                    req;
  asm_wave_t                    wave [ROWS+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_first_eight <= '0;
      pattern_last_eight  <= '0;
      pattern_length      <= '0;
      max_distance        <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_PATTERN_FIRST_EIGHT: pattern_first_eight <= cfg_data;
        REG_PATTERN_LAST_EIGHT:  pattern_last_eight  <= cfg_data;
        REG_PATTERN_LENGTH:      pattern_length      <= cfg_data[DIST_W-1:0];
        REG_MAX_DISTANCE:        max_distance        <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pattern_bytes = {pattern_last_eight, pattern_first_eight};

  // Lengths beyond the number of cells read the last row.
  assign pattern_len = (pattern_length > DIST_W'(ROWS)) ? DIST_W'(ROWS) : pattern_length;

  // Row zero is pinned at distance 0; an empty pattern selects it.
  assign req                 = text.payload;
  assign text.ready          = advance && !rst;
  assign wave[0].valid       = text.valid && !rst;
  assign wave[0].text_byte   = req.text_byte;
  assign wave[0].end_of_text = req.end_of_text;
  assign wave[0].new_dist    = '0;
  assign wave[0].old_dist    = '0;
  assign wave[0].sel_dist    = '0;

  // Row of cells, one per pattern byte.
  for (genvar r = 1; r <= ROWS; r++) begin : g_cell
    asm_cell #(
      .ROW (r)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .pattern_byte (pattern_bytes[BYTE_W*(r-1) +: BYTE_W]),
      .pattern_len  (pattern_len),
      .wave_in      (wave[r-1]),
      .wave_out     (wave[r])
    );
  end

  // Output stage with the sticky found flag.
  asm_result u_result (
    .clk          (clk),
    .rst          (rst),
    .max_distance (max_distance),
    .wave_in      (wave[ROWS]),
    .advance      (advance),
    .result       (result)
  );

endmodule

// ===== rtl/core/asm_cell.sv =====
// ----------------------------------------------------------------------------
// asm_cell: one row of the edit-distance column
// Holds the distance of its pattern row, steps it once per text byte with the
// unit-cost recurrence, and hands the byte and row values to the next cell.
// ----------------------------------------------------------------------------
module asm_cell #(
  parameter int ROW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [asm_pkg::BYTE_W-1:0] pattern_byte,
  input  logic [asm_pkg::DIST_W-1:0] pattern_len,
  input  asm_pkg::asm_wave_t        wave_in,
  output asm_pkg::asm_wave_t        wave_out
);
  import asm_pkg::*;

  localparam logic [DIST_W-1:0] ROW_VALUE = DIST_W'(ROW);

  logic [DIST_W-1:0] row_dist;
  logic [DIST_W:0]   cost_sub;
  logic [DIST_W:0]   cost_del;
  logic [DIST_W:0]   cost_ins;
  logic [DIST_W:0]   cost_min;
  logic [DIST_W-1:0] best;

  // Substitution, deletion and insertion costs; the minimum fits in DIST_W.
  always_comb begin
    cost_sub = {1'b0, wave_in.old_dist} +
               ((pattern_byte != wave_in.text_byte) ? (DIST_W+1)'(1) : (DIST_W+1)'(0));
    cost_del = {1'b0, row_dist} + (DIST_W+1)'(1);
    cost_ins = {1'b0, wave_in.new_dist} + (DIST_W+1)'(1);
    cost_min = cost_sub;
    if (cost_del < cost_min) begin
      cost_min = cost_del;
    end
    if (cost_ins < cost_min) begin
      cost_min = cost_ins;
    end
    best = cost_min[DIST_W-1:0];
  end

  // Row state returns to its reset value after the last byte of a text.
  // The byte moves on with this row's new and previous values.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_dist       <= ROW_VALUE;
      wave_out.valid <= 1'b0;
    end else if (advance) begin
      wave_out.valid       <= wave_in.valid;
      wave_out.text_byte   <= wave_in.text_byte;
      wave_out.end_of_text <= wave_in.end_of_text;
      wave_out.new_dist    <= best;
      wave_out.old_dist    <= row_dist;
      wave_out.sel_dist    <= (pattern_len == ROW_VALUE) ? best : wave_in.sel_dist;
      if (wave_in.valid) begin
        row_dist <= wave_in.end_of_text ? ROW_VALUE : best;
      end
    end
  end

endmodule

// ===== rtl/core/asm_result.sv =====
// ----------------------------------------------------------------------------
// asm_result: output stage of the matcher
// Turns the selected row distance into a result, keeps the sticky found flag
// for the current text and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module asm_result (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [asm_pkg::DIST_W-1:0] max_distance,
  input  asm_pkg::asm_wave_t         wave_in,
  output logic                       advance,
  asm_stream_if.source               result
);
  import asm_pkg::*;

  logic       out_valid;
  logic       found_flag;
  logic       hit;
  match_rsp_t rsp;

  // The whole row moves whenever the output register is free or being taken.
  assign advance = !out_valid || result.ready;

  assign hit = (wave_in.sel_dist <= max_distance);

  // Control: output valid and the sticky flag, which clears after a text ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      found_flag <= 1'b0;
    end else if (advance) begin
      out_valid <= wave_in.valid;
      if (wave_in.valid) begin
        found_flag <= wave_in.end_of_text ? 1'b0 : (found_flag | hit);
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && wave_in.valid) begin
      rsp.end_distance <= wave_in.sel_dist;
      rsp.match_here   <= hit;
      rsp.found        <= found_flag | hit;
      rsp.last_result  <= wave_in.end_of_text;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = rsp;

endmodule

// ===== rtl/core/asm_checker.sv =====
// ----------------------------------------------------------------------------
// asm_checker: port-level checks of the approximate substring matcher
// Watches the result channel for held results, distance range and the
// behavior of the found flag across text boundaries.
// ----------------------------------------------------------------------------
module asm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [asm_pkg::DIST_W-1:0] end_distance,
  input logic                       match_here,
  input logic                       found,
  input logic                       last_result
);
  import asm_pkg::*;

  logic text_start;

  // Set when the next result opens a new text.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_start <= 1'b1;
    end else if (rsp_valid && rsp_ready) begin
      text_start <= last_result;
    end
  end

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(end_distance) &&
      $stable(match_here) && $stable(found) && $stable(last_result))
    else $error("result changed while stalled");

  // A match always raises the found flag.
  a_match_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && match_here |-> found)
    else $error("match without found");

  // The first result of a text reports found only through its own match.
  a_fresh_text: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && text_start |-> found == match_here)
    else $error("found carried over from previous text");

  // A distance never exceeds the pattern storage.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> end_distance <= DIST_W'(PATTERN_BYTES))
    else $error("distance out of range");

endmodule

bind approximate_substring_match_top asm_checker u_asm_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (result.valid),
  .rsp_ready    (result.ready),
  .end_distance (result.payload.end_distance),
  .match_here   (result.payload.match_here),
  .found        (result.payload.found),
  .last_result  (result.payload.last_result)
);
